[rtl/core/gbba_pkg.sv]
// Shared package for the grouped bitmap block allocator.
// Holds field widths, request kinds, status codes, internal op codes and the queue entry type.
// No dependencies.
package gbba_pkg;

   localparam int BPG_DEFAULT = 1024;
   localparam int GC_DEFAULT  = 16;

   localparam int KIND_W   = 2;
   localparam int BLOCK_W  = 14;
   localparam int STATUS_W = 3;

   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY_USED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd4;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_RESERVE = 2'd2;
   localparam logic [1:0] OP_REJECT  = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [BLOCK_W-1:0] block;
   } cmd_type;

endpackage

[rtl/core/gbba_if.sv]
// Request and response channel interfaces of the grouped bitmap block allocator.
// Depends on gbba_pkg for the payload widths.
interface gbba_req_if;
   import gbba_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [BLOCK_W-1:0] block_number;
   modport source (output valid, kind, block_number, input ready);
   modport sink   (input valid, kind, block_number, output ready);
endinterface

interface gbba_rsp_if;
   import gbba_pkg::*;
   logic                valid;
   logic                ready;
   logic [BLOCK_W-1:0]  result_block;
   logic [STATUS_W-1:0] status;
   modport source (output valid, result_block, status, input ready);
   modport sink   (input valid, result_block, status, output ready);
endinterface

[rtl/core/grouped_bitmap_block_allocator.sv]
// Grouped bitmap block allocator, top level: allocate, free and reserve blocks over a used-bit
// bitmap held in a RAM of 32-bit words, with per-group used counts and first-free hints. After
// reset a clearing pass writes zero to every bitmap word; requests queue up meanwhile but are
// served after it. One request is served at a time, with a response register in front of rsp_if.
// Reject and out-of-range requests are answered without a bitmap access; free and reserve read
// the bitmap word and write it back when the bit changes. An allocate reads the hinted word,
// then reads following words of the group when the forward search for the next free bit leaves
// the current word (up to BLOCKS_PER_GROUP/32 - 1), and examines groups when the group hint
// must be refreshed (up to GROUP_COUNT).
// Depends on gbba_pkg, gbba_if, gbba_front, gbba_queue and gbba_back.
module grouped_bitmap_block_allocator #(
   parameter int BLOCKS_PER_GROUP = gbba_pkg::BPG_DEFAULT,
   parameter int GROUP_COUNT      = gbba_pkg::GC_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   gbba_req_if.sink   req_if,
   gbba_rsp_if.source rsp_if
);
   import gbba_pkg::*;

   logic    push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_cmd, pop_cmd;

   gbba_front #(.BLOCKS_PER_GROUP(BLOCKS_PER_GROUP), .GROUP_COUNT(GROUP_COUNT)) u_front (
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   gbba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   gbba_back #(.BLOCKS_PER_GROUP(BLOCKS_PER_GROUP), .GROUP_COUNT(GROUP_COUNT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_if    (rsp_if)
   );
endmodule

[rtl/core/gbba_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module gbba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/gbba_front.sv]
// Front end of the allocator: takes requests and classifies them into internal ops.
// Depends on gbba_pkg and gbba_if.
module gbba_front #(
   parameter int BLOCKS_PER_GROUP = gbba_pkg::BPG_DEFAULT,
   parameter int GROUP_COUNT      = gbba_pkg::GC_DEFAULT
) (
   gbba_req_if.sink         req_if,
   output logic             push_valid,
   input  logic             push_ready,
   output gbba_pkg::cmd_type push_cmd
);
   import gbba_pkg::*;

   localparam int TOTAL = BLOCKS_PER_GROUP * GROUP_COUNT;

   logic in_range;

   assign in_range   = 32'(req_if.block_number) < TOTAL;
   assign push_valid = req_if.valid;
   assign req_if.ready = push_ready;

   always_comb begin
      push_cmd.block = req_if.block_number;
      unique case (req_if.kind)
         KIND_ALLOC:   push_cmd.op = OP_ALLOC;
         KIND_FREE:    push_cmd.op = in_range ? OP_FREE : OP_REJECT;
         KIND_RESERVE: push_cmd.op = in_range ? OP_RESERVE : OP_REJECT;
         default:      push_cmd.op = OP_REJECT;
      endcase
   end
endmodule

[rtl/core/gbba_queue.sv]
// Two-entry queue of classified ops between the front and back ends.
// Depends on gbba_pkg.
module gbba_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  gbba_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output gbba_pkg::cmd_type pop_cmd
);
   import gbba_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

[rtl/core/gbba_back.sv]
// Back end of the allocator: bitmap RAM, group metadata, forward and group scans.
// Depends on gbba_pkg, gbba_if and gbba_ram.
module gbba_back #(
   parameter int BLOCKS_PER_GROUP = gbba_pkg::BPG_DEFAULT,
   parameter int GROUP_COUNT      = gbba_pkg::GC_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  gbba_pkg::cmd_type pop_cmd,
   gbba_rsp_if.source        rsp_if
);
   import gbba_pkg::*;

   localparam int W       = (BLOCKS_PER_GROUP < 32) ? BLOCKS_PER_GROUP : 32;
   localparam int WB      = $clog2(W);
   localparam int WPG     = BLOCKS_PER_GROUP / W;
   localparam int WPGW    = (WPG > 1) ? $clog2(WPG) : 1;
   localparam int TOTAL   = BLOCKS_PER_GROUP * GROUP_COUNT;
   localparam int WORDS   = TOTAL / W;
   localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int TW      = $clog2(TOTAL);
   localparam int LOG_BPG = $clog2(BLOCKS_PER_GROUP);
   localparam int OFW     = LOG_BPG;
   localparam int OW      = $clog2(BLOCKS_PER_GROUP + 1);
   localparam int GW      = $clog2(GROUP_COUNT + 1);
   localparam int GIW     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_RESCAN = 3'd4;

   localparam logic CONT_FINISH = 1'b0;
   localparam logic CONT_ALLOC  = 1'b1;

   function automatic logic [WB:0] find_zero(input logic [W-1:0] word);
      logic [WB:0] r;
      r = '0;
      for (int i = W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            r = {1'b1, WB'(i)};
         end
      end
      return r;
   endfunction

   function automatic logic [TW-1:0] make_blk(input logic [GIW-1:0] g, input logic [OW-1:0] f);
      return TW'((32'(g) << LOG_BPG) | 32'(f));
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [TW-1:0]       cur_ff, cur_in;
   logic [BLOCK_W-1:0]  res_ff, res_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [GW-1:0]       hint_ff, hint_in;
   logic [OW-1:0]       count_ff [GROUP_COUNT];
   logic [OW-1:0]       count_in [GROUP_COUNT];
   logic [OW-1:0]       first_ff [GROUP_COUNT];
   logic [OW-1:0]       first_in [GROUP_COUNT];
   logic [GROUP_COUNT-1:0] space_ff, space_in;
   logic [GIW-1:0]      gidx_ff, gidx_in;
   logic                cont_ff, cont_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [WPGW-1:0]     sword_ff, sword_in;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [W-1:0]  ram_wr_data, ram_rd_data;

   logic [GIW-1:0]  cur_g, hint_idx;
   logic [OFW-1:0]  cur_off;
   logic [AW-1:0]   cur_waddr;
   logic [WB-1:0]   cur_bit;
   logic [WPGW-1:0] cur_wig;
   logic [W-1:0]    bit_mask, le_mask, set_word, clr_word;
   logic            rd_bit, hint_is_g, hint_none, cur_last, sword_last;
   logic [WB:0]     zero_above, zero_scan;
   logic [OW-1:0]   cnt_g, first_g, cnt_inc;

   gbba_ram #(.WIDTH(W), .DEPTH(WORDS)) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign cur_g      = GIW'(cur_ff >> LOG_BPG);
   assign cur_off    = OFW'(cur_ff);
   assign cur_waddr  = AW'(cur_ff >> WB);
   assign cur_bit    = WB'(cur_ff);
   assign cur_wig    = WPGW'(cur_ff >> WB);
   assign hint_idx   = GIW'(hint_ff);
   assign bit_mask   = W'(1) << cur_bit;
   assign le_mask    = (bit_mask << 1) - W'(1);
   assign rd_bit     = ram_rd_data[cur_bit];
   assign set_word   = ram_rd_data | bit_mask;
   assign clr_word   = ram_rd_data & ~bit_mask;
   assign zero_above = find_zero(set_word | le_mask);
   assign zero_scan  = find_zero(ram_rd_data);
   assign cnt_g      = count_ff[cur_g];
   assign first_g    = first_ff[cur_g];
   assign cnt_inc    = cnt_g + OW'(1);
   assign hint_is_g  = 32'(hint_ff) == 32'(cur_g);
   assign hint_none  = 32'(hint_ff) >= GROUP_COUNT;
   assign cur_last   = (WPG == 1) || (cur_wig == WPGW'(WPG - 1));
   assign sword_last = (WPG == 1) || (sword_ff == WPGW'(WPG - 1));

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_block = res_ff;
   assign rsp_if.status       = status_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      hint_in      = hint_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      space_in     = space_ff;
      gidx_in      = gidx_ff;
      cont_in      = cont_ff;
      addr_in      = addr_ff;
      sword_in     = sword_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_waddr;
      ram_wr_data  = set_word;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cur_waddr;
      pop_ready    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff;
            ram_wr_data = '0;
            addr_in     = addr_ff + AW'(1);
            if (addr_ff == AW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (pop_valid && !rsp_valid_ff) begin
               pop_ready = 1'b1;
               op_in     = pop_cmd.op;
               case (pop_cmd.op)
                  OP_ALLOC: begin
                     if (!hint_none && space_ff[hint_idx]) begin
                        cur_in      = make_blk(hint_idx, first_ff[hint_idx]);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(cur_in >> WB);
                        state_in    = S_CHECK;
                     end else begin
                        gidx_in  = '0;
                        cont_in  = CONT_ALLOC;
                        state_in = S_RESCAN;
                     end
                  end
                  OP_FREE, OP_RESERVE: begin
                     cur_in      = TW'(pop_cmd.block);
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = AW'(32'(pop_cmd.block) >> WB);
                     state_in    = S_CHECK;
                  end
                  default: begin
                     res_in       = pop_cmd.block;
                     status_in    = ST_RANGE;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_CHECK: begin
            res_in    = BLOCK_W'(cur_ff);
            status_in = ST_OK;
            if (op_ff == OP_FREE) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (!rd_bit) begin
                  status_in = ST_ALREADY_FREE;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = clr_word;
                  if (cnt_g != '0) begin
                     count_in[cur_g] = cnt_g - OW'(1);
                  end
                  if (first_g > OW'(cur_off)) begin
                     first_in[cur_g] = OW'(cur_off);
                  end
                  space_in[cur_g] = 1'b1;
                  hint_in         = GW'(cur_g);
               end
            end else if (op_ff == OP_RESERVE && rd_bit) begin
               status_in    = ST_ALREADY_USED;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               ram_wr_en       = 1'b1;
               count_in[cur_g] = cnt_inc;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
               if (32'(cnt_inc) >= BLOCKS_PER_GROUP) begin
                  first_in[cur_g] = OW'(BLOCKS_PER_GROUP);
                  space_in[cur_g] = 1'b0;
                  if (hint_is_g || hint_none) begin
                     rsp_valid_in = 1'b0;
                     gidx_in      = '0;
                     cont_in      = CONT_FINISH;
                     state_in     = S_RESCAN;
                  end
               end else if (first_g == OW'(cur_off)) begin
                  if (zero_above[WB]) begin
                     first_in[cur_g] = OW'((32'(cur_off) >> WB) << WB) + OW'(zero_above[WB-1:0]);
                  end else if (cur_last) begin
                     first_in[cur_g] = OW'(BLOCKS_PER_GROUP);
                     space_in[cur_g] = 1'b0;
                     if (hint_is_g) begin
                        rsp_valid_in = 1'b0;
                        gidx_in      = '0;
                        cont_in      = CONT_FINISH;
                        state_in     = S_RESCAN;
                     end
                  end else begin
                     rsp_valid_in = 1'b0;
                     addr_in      = cur_waddr + AW'(1);
                     sword_in     = cur_wig + WPGW'(1);
                     ram_rd_en    = 1'b1;
                     ram_rd_addr  = cur_waddr + AW'(1);
                     state_in     = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (zero_scan[WB]) begin
               first_in[cur_g] = OW'(32'(sword_ff) << WB) + OW'(zero_scan[WB-1:0]);
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else if (sword_last) begin
               first_in[cur_g] = OW'(BLOCKS_PER_GROUP);
               space_in[cur_g] = 1'b0;
               if (hint_is_g) begin
                  gidx_in  = '0;
                  cont_in  = CONT_FINISH;
                  state_in = S_RESCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               addr_in     = addr_ff + AW'(1);
               sword_in    = sword_ff + WPGW'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = addr_ff + AW'(1);
            end
         end
         S_RESCAN: begin
            if (space_ff[gidx_ff]) begin
               hint_in = GW'(gidx_ff);
               if (cont_ff == CONT_ALLOC) begin
                  cur_in      = make_blk(gidx_ff, first_ff[gidx_ff]);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'(cur_in >> WB);
                  state_in    = S_CHECK;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (32'(gidx_ff) == GROUP_COUNT - 1) begin
               hint_in      = GW'(GROUP_COUNT);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (cont_ff == CONT_ALLOC) begin
                  res_in    = '0;
                  status_in = ST_FULL;
               end
            end else begin
               gidx_in = gidx_ff + GIW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         op_ff        <= OP_ALLOC;
         rsp_valid_ff <= 1'b0;
         hint_ff      <= '0;
         space_ff     <= '1;
         gidx_ff      <= '0;
         cont_ff      <= CONT_FINISH;
         addr_ff      <= '0;
         for (int i = 0; i < GROUP_COUNT; i++) begin
            count_ff[i] <= '0;
            first_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         hint_ff      <= hint_in;
         space_ff     <= space_in;
         gidx_ff      <= gidx_in;
         cont_ff      <= cont_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      sword_ff  <= sword_in;
   end
endmodule

[rtl/core/gbba_checker.sv]
// Port-level checker for the grouped bitmap block allocator, bound to the top level.
// Depends on gbba_pkg and grouped_bitmap_block_allocator.
module gbba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [gbba_pkg::BLOCK_W-1:0]  result_block,
   input logic [gbba_pkg::STATUS_W-1:0] status
);
   import gbba_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_block) && $stable(status))
      else $error("response changed while stalled");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_FULL |-> result_block == '0)
      else $error("full status with nonzero block");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status <= ST_RANGE)
      else $error("undefined status code");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response out of reset");
endmodule

bind grouped_bitmap_block_allocator gbba_checker u_gbba_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .result_block (rsp_if.result_block),
   .status       (rsp_if.status)
);

[test/gbba_checker.sv]
// Checker for the grouped bitmap block allocator: watches both channels, keeps its own
// copy of the bitmap and group metadata, predicts each response and compares it.
// Depends on gbba_pkg and gbba_if.
module gbba_scoreboard (
   input  logic clock,
   input  logic reset,
   gbba_req_if  req,
   gbba_rsp_if  rsp,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import gbba_pkg::*;

   localparam int BPG   = BPG_DEFAULT;
   localparam int GC    = GC_DEFAULT;
   localparam int TOTAL = BPG * GC;

   typedef struct {
      logic [BLOCK_W-1:0]  blk;
      logic [STATUS_W-1:0] status;
   } grant_type;

   bit          used_map [TOTAL];
   int unsigned grp_used [GC];
   int unsigned grp_first[GC];
   int unsigned spare_grp;
   grant_type   grant_q[$];

   function automatic void find_spare_group();
      spare_grp = GC;
      for (int g = 0; g < GC; g++) begin
         if (grp_first[g] < BPG) begin
            spare_grp = g;
            return;
         end
      end
   endfunction

   function automatic void take_block(int unsigned g, int unsigned off);
      used_map[g*BPG + off] = 1'b1;
      grp_used[g]++;
      if (grp_used[g] >= BPG) begin
         grp_first[g] = BPG;
         if (spare_grp == g || spare_grp >= GC) find_spare_group();
      end else if (grp_first[g] == off) begin
         grp_first[g] = BPG;
         for (int unsigned i = off + 1; i < BPG; i++) begin
            if (!used_map[g*BPG + i]) begin
               grp_first[g] = i;
               break;
            end
         end
         if (grp_first[g] >= BPG && spare_grp == g) find_spare_group();
      end
   endfunction

   function automatic grant_type serve_request(logic [KIND_W-1:0] kind,
                                              logic [BLOCK_W-1:0] blk);
      grant_type   r;
      int unsigned g, off;
      bit          ok;
      r.blk    = blk;
      r.status = ST_OK;
      if (kind == KIND_ALLOC) begin
         g  = spare_grp;
         ok = 0;
         if (g < GC) ok = grp_first[g] < BPG && !used_map[g*BPG + grp_first[g]];
         if (!ok) begin
            find_spare_group();
            g  = spare_grp;
            ok = g < GC && !used_map[g*BPG + grp_first[g]];
         end
         if (ok) begin
            r.blk = BLOCK_W'(g*BPG + grp_first[g]);
            take_block(g, grp_first[g]);
         end else begin
            r.blk    = '0;
            r.status = ST_FULL;
         end
      end else if (kind == KIND_FREE || kind == KIND_RESERVE) begin
         if (blk >= TOTAL) begin
            r.status = ST_RANGE;
         end else begin
            g   = blk / BPG;
            off = blk % BPG;
            if (kind == KIND_FREE) begin
               if (!used_map[blk]) begin
                  r.status = ST_ALREADY_FREE;
               end else begin
                  used_map[blk] = 1'b0;
                  if (grp_used[g] > 0) grp_used[g]--;
                  if (grp_first[g] > off) grp_first[g] = off;
                  spare_grp = g;
               end
            end else if (used_map[blk]) begin
               r.status = ST_ALREADY_USED;
            end else begin
               take_block(g, off);
            end
         end
      end else begin
         r.status = ST_RANGE;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         foreach (used_map[i]) used_map[i] = 1'b0;
         foreach (grp_used[i]) begin
            grp_used[i]  = 0;
            grp_first[i] = 0;
         end
         spare_grp  = 0;
         fail_count = 0;
         grant_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (grant_q.size() == 0) begin
               $display("%0t: unexpected response block %0d status %0d", $realtime,
                        rsp.result_block, rsp.status);
               fail_count++;
            end else begin
               want = grant_q.pop_front();
               if (rsp.result_block !== want.blk || rsp.status !== want.status) begin
                  $display("%0t: mismatch expected block %0d status %0d, got block %0d status %0d",
                           $realtime, want.blk, want.status, rsp.result_block, rsp.status);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready)
            grant_q.push_back(serve_request(req.kind, req.block_number));
      end
      pending = grant_q.size();
   end
endmodule

[test/tb_top.sv]
// Testbench top for the grouped bitmap block allocator: clock, reset, request stimulus
// with bursty gaps, response stalls, and the verdict. Depends on gbba_pkg, gbba_if,
// gbba_checker and the allocator RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gbba_pkg::*;

   localparam int TOTAL = BPG_DEFAULT * GC_DEFAULT;
   localparam int LIMIT = 4000000;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic req_fire;
   int   fail_count;
   int   pending;
   int   cycles;
   int   burst_left;
   int   stall_mode;
   int   alloc_sent;

   gbba_req_if req_if();
   gbba_rsp_if rsp_if();

   grouped_bitmap_block_allocator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   gbba_scoreboard chk (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      req_fire <= req_if.valid && req_if.ready;
      cycles   <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (cycles % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_if.ready = 1'b1;
         1: rsp_if.ready = $urandom_range(0, 9) < 7;
         2: rsp_if.ready = $urandom_range(0, 9) < 3;
         default: rsp_if.ready = (cycles % 5) != 0;
      endcase
   end

   task automatic send(logic [KIND_W-1:0] kind, logic [BLOCK_W-1:0] blk);
      if (burst_left == 0) begin
         req_if.valid = 1'b0;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_if.valid        = 1'b1;
      req_if.kind         = kind;
      req_if.block_number = blk;
      if (kind == KIND_ALLOC) alloc_sent++;
      do @(negedge clock); while (!req_fire);
      burst_left--;
   endtask

   function automatic logic [BLOCK_W-1:0] near_block();
      int hi;
      hi = alloc_sent + 40;
      if (hi > TOTAL - 1) hi = TOTAL - 1;
      return BLOCK_W'($urandom_range(0, hi));
   endfunction

   task automatic mixed_item(bit wide);
      int pick;
      logic [BLOCK_W-1:0] b;
      pick = $urandom_range(0, 99);
      b    = wide ? BLOCK_W'($urandom_range(0, TOTAL - 1)) : near_block();
      if (pick < 45)      send(KIND_ALLOC, BLOCK_W'($urandom));
      else if (pick < 75) send(KIND_FREE, b);
      else if (pick < 95) send(KIND_RESERVE, b);
      else                send(KIND_UNUSED, BLOCK_W'($urandom));
   endtask

   initial begin
      logic [BLOCK_W-1:0] b;
      cycles              = 0;
      burst_left          = 0;
      alloc_sent          = 0;
      stall_mode          = 0;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.kind         = KIND_ALLOC;
      req_if.block_number = '0;
      rsp_if.ready        = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      send(KIND_ALLOC, '1);
      send(KIND_ALLOC, '0);
      send(KIND_FREE, 14'd0);
      send(KIND_FREE, 14'd0);
      send(KIND_ALLOC, 14'h2AAA);
      send(KIND_RESERVE, 14'd1);
      send(KIND_RESERVE, 14'd2);
      send(KIND_RESERVE, 14'd2);
      send(KIND_RESERVE, 14'd16383);
      send(KIND_RESERVE, 14'd1023);
      send(KIND_FREE, 14'd16383);
      send(KIND_FREE, 14'd16383);
      send(KIND_FREE, 14'h1555);
      send(KIND_UNUSED, 14'h3FFF);
      send(KIND_UNUSED, 14'h0000);
      send(KIND_ALLOC, '0);
      send(KIND_FREE, 14'd1023);
      send(KIND_ALLOC, '0);
      send(KIND_RESERVE, 14'd1024);
      send(KIND_ALLOC, '0);

      repeat (1000) mixed_item(0);

      // free a random block, then reserve it again or allocate, then allocate
      repeat (40) begin
         b = BLOCK_W'($urandom_range(0, TOTAL - 1));
         send(KIND_FREE, b);
         if ($urandom_range(0, 1)) send(KIND_RESERVE, b);
         else send(KIND_ALLOC, BLOCK_W'($urandom));
         send(KIND_ALLOC, BLOCK_W'($urandom));
      end
      repeat (160) mixed_item(1);

      req_if.valid = 1'b0;
      wait (pending == 0);
      repeat (60) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

[grouped_bitmap_block_allocator.f]
rtl/core/gbba_pkg.sv
rtl/core/gbba_if.sv
rtl/core/gbba_ram.sv
rtl/core/gbba_front.sv
rtl/core/gbba_queue.sv
rtl/core/gbba_back.sv
rtl/core/grouped_bitmap_block_allocator.sv
rtl/core/gbba_checker.sv
test/gbba_checker.sv
test/tb_top.sv
